### src/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher core.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int PERM_DEPTH        = 256;
  localparam int PERM_AW           = 8;
  localparam int DEF_MAX_KEY_BYTES = 64;
  localparam int KEYLEN_W          = 7;
  localparam int SLOT_W            = 6;
  localparam int OPC_W             = 2;
  localparam int IN_TDATA_W        = 24;
  localparam int OUT_TDATA_W       = 8;
  localparam int LEN_W             = 9;

  localparam logic [KEYLEN_W-1:0] KEYLEN_RESET = 7'd64;

  // request opcodes carried on in_tuser
  localparam logic [OPC_W-1:0] OP_KEY_WR = 2'd0;
  localparam logic [OPC_W-1:0] OP_SCHED  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CRYPT  = 2'd2;

  // permutation read address select
  localparam logic [1:0] RD_SEL_I     = 2'd0;
  localparam logic [1:0] RD_SEL_I_INC = 2'd1;
  localparam logic [1:0] RD_SEL_J_SUM = 2'd2;
  localparam logic [1:0] RD_SEL_T     = 2'd3;

  // permutation write select
  localparam logic WR_SEL_I_Q = 1'b0;  // S[i] <= read data
  localparam logic WR_SEL_J_A = 1'b1;  // S[j] <= held S[i]

  typedef struct packed {
    logic       init;        // reset permutation to identity, clear i, j, slot
    logic       key_wr;      // write key store from request fields
    logic       din_load;    // latch data byte
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       key_add;     // add key byte into j sum
    logic       wr_en;
    logic       wr_sel;
    logic       load_i_inc;
    logic       load_j_sum;
    logic       load_a;
    logic       load_bt;
    logic       sched_step;  // advance schedule counter and key slot
    logic       out_load;
  } rc4_cmd_t;

  typedef struct packed {
    logic last_iter;  // schedule counter at final entry
    logic out_stall;  // result register full and not taken
  } rc4_sts_t;

endpackage

`default_nettype wire

### src/rc4_ctrl.sv
// Controller state machine sequencing key writes, key schedule and crypt.
`default_nettype none

module rc4_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [rc4_pkg::OPC_W-1:0] in_tuser,
  input  rc4_pkg::rc4_sts_t        sts,
  output rc4_pkg::rc4_cmd_t        cmd
);
  import rc4_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCH_RD_N = 4'd1;
  localparam logic [3:0] ST_SCH_RD_J = 4'd2;
  localparam logic [3:0] ST_SCH_WR_N = 4'd3;
  localparam logic [3:0] ST_SCH_WR_J = 4'd4;
  localparam logic [3:0] ST_CR_RD_I  = 4'd5;
  localparam logic [3:0] ST_CR_RD_J  = 4'd6;
  localparam logic [3:0] ST_CR_RD_T  = 4'd7;
  localparam logic [3:0] ST_CR_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_tuser == OP_KEY_WR) begin
            cmd.key_wr = 1'b1;
          end else if (in_tuser == OP_SCHED) begin
            cmd.init  = 1'b1;
            state_nxt = ST_SCH_RD_N;
          end else if (in_tuser == OP_CRYPT) begin
            cmd.din_load = 1'b1;
            state_nxt    = ST_CR_RD_I;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCH_RD_N: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SEL_I;
        state_nxt  = ST_SCH_RD_J;
      end
      ST_SCH_RD_J: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_SEL_J_SUM;
        cmd.key_add    = 1'b1;
        cmd.load_j_sum = 1'b1;
        cmd.load_a     = 1'b1;
        state_nxt      = ST_SCH_WR_N;
      end
      ST_SCH_WR_N: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SEL_I_Q;
        state_nxt  = ST_SCH_WR_J;
      end
      ST_SCH_WR_J: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = WR_SEL_J_A;
        cmd.sched_step = 1'b1;
        state_nxt      = sts.last_iter ? ST_IDLE : ST_SCH_RD_N;
      end
      ST_CR_RD_I: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_SEL_I_INC;
        cmd.load_i_inc = 1'b1;
        state_nxt      = ST_CR_RD_J;
      end
      ST_CR_RD_J: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_SEL_J_SUM;
        cmd.load_j_sum = 1'b1;
        cmd.load_a     = 1'b1;
        state_nxt      = ST_CR_RD_T;
      end
      ST_CR_RD_T: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_SEL_T;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SEL_I_Q;
        cmd.load_bt = 1'b1;
        state_nxt   = ST_CR_OUT;
      end
      ST_CR_OUT: begin
        if (!sts.out_stall) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_SEL_J_A;
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### src/rc4_dp.sv
// Datapath: permutation and key memories, indices, key length and result register.
`default_nettype none

module rc4_dp #(
  parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  rc4_pkg::rc4_cmd_t               cmd,
  output rc4_pkg::rc4_sts_t               sts,
  input  wire  [rc4_pkg::SLOT_W-1:0]      key_slot,
  input  wire  [rc4_pkg::BYTE_W-1:0]      key_byte,
  input  wire  [rc4_pkg::BYTE_W-1:0]      data_in,
  input  wire                             cfg_wr_en,
  input  wire  [rc4_pkg::KEYLEN_W-1:0]    cfg_wr_data,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [rc4_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rc4_pkg::*;

  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEY_BYTES);

  // permutation store with identity-on-clear valid bits
  logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] vld_r;
  logic [BYTE_W-1:0]     mem_q_r;
  logic                  rd_vld_r;
  logic [PERM_AW-1:0]    rd_addr_q_r;
  logic [BYTE_W-1:0]     perm_q;

  logic [BYTE_W-1:0]     key_mem [MAX_KEY_BYTES];
  logic [BYTE_W-1:0]     key_q_r;

  logic [PERM_AW-1:0]    i_r, j_r, t_r;
  logic [BYTE_W-1:0]     a_r, b_r, din_r;
  logic [KEY_AW-1:0]     slot_r;
  logic [KEYLEN_W-1:0]   key_len_r;
  logic [BYTE_W-1:0]     out_data_r;
  logic                  out_vld_r;

  logic [PERM_AW-1:0]    i_inc, j_sum, t_sum, rd_addr, wr_addr;
  logic [BYTE_W-1:0]     wr_data, key_term, ks;
  logic [LEN_W-1:0]      len_eff, slot_plus;
  logic                  slot_ok;

  assign perm_q   = rd_vld_r ? mem_q_r : rd_addr_q_r;
  assign i_inc    = i_r + 1'b1;
  assign key_term = cmd.key_add ? key_q_r : '0;
  assign j_sum    = PERM_AW'(j_r + perm_q + key_term);
  assign t_sum    = PERM_AW'(a_r + perm_q);

  // key length clamped to 1..MAX_KEY_BYTES
  always_comb begin
    priority if (key_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(key_len_r) > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LEN_W'(key_len_r);
    end
  end

  assign slot_plus = LEN_W'(slot_r) + LEN_W'(1);
  assign slot_ok   = (LEN_W'(key_slot) < MAX_LEN);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SEL_I:     rd_addr = i_r;
      RD_SEL_I_INC: rd_addr = i_inc;
      RD_SEL_J_SUM: rd_addr = j_sum;
      RD_SEL_T:     rd_addr = t_sum;
      default:      rd_addr = i_r;
    endcase
  end

  assign wr_addr = (cmd.wr_sel == WR_SEL_J_A) ? j_r : i_r;
  assign wr_data = (cmd.wr_sel == WR_SEL_J_A) ? a_r : perm_q;

  // keystream byte; entries swapped this item bypass the memory
  always_comb begin
    priority if (t_r == j_r) begin
      ks = a_r;
    end else if (t_r == i_r) begin
      ks = b_r;
    end else begin
      ks = perm_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q_r     <= perm_mem[rd_addr];
      rd_addr_q_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cmd.init) begin
        vld_r <= '0;
      end else if (cmd.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr && slot_ok) begin
      key_mem[KEY_AW'(key_slot)] <= key_byte;
    end
    key_q_r <= key_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.din_load) din_r <= data_in;
    if (cmd.load_a)   a_r   <= perm_q;
    if (cmd.load_bt) begin
      b_r <= perm_q;
      t_r <= t_sum;
    end
    if (cmd.out_load) out_data_r <= din_r ^ ks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r       <= '0;
      j_r       <= '0;
      slot_r    <= '0;
      key_len_r <= KEYLEN_RESET;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_len_r <= cfg_wr_data;
      end
      if (cmd.init) begin
        i_r    <= '0;
        j_r    <= '0;
        slot_r <= '0;
      end else begin
        if (cmd.load_i_inc) begin
          i_r <= i_inc;
        end
        if (cmd.load_j_sum) begin
          j_r <= j_sum;
        end
        if (cmd.sched_step) begin
          i_r    <= i_inc;
          slot_r <= (slot_plus >= len_eff) ? '0 : KEY_AW'(slot_plus);
          if (sts.last_iter) begin
            j_r <= '0;
          end
        end
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.last_iter = (i_r == PERM_AW'(PERM_DEPTH - 1));
  assign sts.out_stall = out_vld_r & ~out_tready;
  assign out_tvalid    = out_vld_r;
  assign out_tdata     = out_data_r;

endmodule

`default_nettype wire

### src/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher core: controller plus datapath.
//
// Usage:
//  - Input stream (in_*): one request per accepted beat. in_tuser holds the
//    opcode: write key byte, run key schedule, or crypt one data byte.
//    Opcode 3 is accepted and dropped.
//  - Output stream (out_*): one result per crypt request, data_in XOR keystream.
//  - cfg_wr_en / cfg_wr_data: key length register (clamped to 1..MAX_KEY_BYTES),
//    the user must write it only while the core is idle; not enforced by the core.
//  - Sequencing: requests are taken one at a time from the idle state. A key
//    write is stored on acceptance. A crypt runs a read, read, swap-and-read,
//    swap sequence on the single read port of the permutation memory; the swap
//    step also loads the result register. A key schedule resets the permutation
//    to identity, then runs read, read, write, write for each of the 256 entries.
//  - Reset: synchronous, active low. The permutation reads as identity through
//    per-entry valid bits cleared at once (no clearing pass), indices are zero,
//    key length is 64. The key store is undefined until written.
//  - Stall: a finished result sits in the output register; the core still
//    accepts the next request and only holds in its final crypt step if the
//    previous result has not been taken.
`default_nettype none

module rc4_stream_cipher_core #(
  parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // in_tdata: key_slot[5:0], key_byte[13:6], data_in[21:14], zero [23:22]
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [rc4_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0]
  input  wire  [rc4_pkg::OPC_W-1:0]       in_tuser,
  // out_tdata: data_out[7:0]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [rc4_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                             cfg_wr_en,
  input  wire  [rc4_pkg::KEYLEN_W-1:0]    cfg_wr_data
);
  import rc4_pkg::*;

  rc4_cmd_t cmd;
  rc4_sts_t sts;

  // request field unpacking
  logic [SLOT_W-1:0] key_slot;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] data_in;

  assign key_slot = in_tdata[5:0];
  assign key_byte = in_tdata[13:6];
  assign data_in  = in_tdata[21:14];

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .key_slot    (key_slot),
    .key_byte    (key_byte),
    .data_in     (data_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

### test/tb_rc4_stream_cipher_core.sv
// Self-checking testbench for the RC4 stream cipher core: directed and random requests.
`default_nettype none

module tb_rc4_stream_cipher_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  // Opcode 3 has no name in the package; the core takes it and drops it.
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 700;
  // The core can still be busy with a key schedule after the last result is
  // in, so a config write waits this long first.
  localparam int SCHED_DRAIN = 1100;
  localparam int TIMEOUT_NS  = 5_000_000;

  // Receiver behavior: always ready, coin flip per cycle, or a held stall.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_HOLD} rx_mode_e;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [OPC_W-1:0]       in_tuser    = OP_KEY_WR;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [KEYLEN_W-1:0]    cfg_wr_data = '0;

  // Predicted cipher state, kept in step with every accepted request.
  logic [BYTE_W-1:0]   perm_s  [PERM_DEPTH];
  logic [BYTE_W-1:0]   key_mem [DEF_MAX_KEY_BYTES];
  logic [BYTE_W-1:0]   idx_i;
  logic [BYTE_W-1:0]   idx_j;
  logic [KEYLEN_W-1:0] key_len_reg;

  // Expected data_out bytes, oldest first.
  logic [BYTE_W-1:0] crypt_out_q [$];
  logic [BYTE_W-1:0] want_byte;

  int unsigned n_sent     = 0;
  int unsigned n_errors   = 0;
  int unsigned burst_left = 0;

  rx_mode_e    rx_mode    = RX_OPEN;
  int unsigned rx_left    = 0;

  rc4_stream_cipher_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs or drops a result.
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Key length as the schedule uses it: zero acts as one, large values clamp.
  function automatic int unsigned eff_key_len();
    if (key_len_reg == 0) return 1;
    if (key_len_reg > DEF_MAX_KEY_BYTES) return DEF_MAX_KEY_BYTES;
    return key_len_reg;
  endfunction

  function automatic void reset_cipher_state();
    for (int n = 0; n < PERM_DEPTH; n++) perm_s[n] = n[BYTE_W-1:0];
    for (int n = 0; n < DEF_MAX_KEY_BYTES; n++) key_mem[n] = '0;
    idx_i       = '0;
    idx_j       = '0;
    key_len_reg = KEYLEN_RESET;
  endfunction

  // Standard RC4 key scheduling over the first eff_key_len() key bytes.
  function automatic void run_key_schedule();
    int unsigned       len;
    int unsigned       slot;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] t;
    len  = eff_key_len();
    slot = 0;
    j    = '0;
    for (int n = 0; n < PERM_DEPTH; n++) perm_s[n] = n[BYTE_W-1:0];
    for (int n = 0; n < PERM_DEPTH; n++) begin
      j         = j + perm_s[n] + key_mem[slot];
      t         = perm_s[n];
      perm_s[n] = perm_s[j];
      perm_s[j] = t;
      slot++;
      if (slot >= len) slot = 0;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // One PRGA step; returns the keystream byte.
  function automatic logic [BYTE_W-1:0] next_keystream();
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] sum_ij;
    idx_i         = idx_i + 8'd1;
    idx_j         = idx_j + perm_s[idx_i];
    t             = perm_s[idx_i];
    perm_s[idx_i] = perm_s[idx_j];
    perm_s[idx_j] = t;
    sum_ij        = perm_s[idx_i] + perm_s[idx_j];
    return perm_s[sum_ij];
  endfunction

  function automatic void predict_request(input logic [OPC_W-1:0]  opcode,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [BYTE_W-1:0] kbyte,
                                          input logic [BYTE_W-1:0] din);
    case (opcode)
      OP_KEY_WR: key_mem[slot] = kbyte;
      OP_SCHED:  run_key_schedule();
      OP_CRYPT:  crypt_out_q.push_back(din ^ next_keystream());
      default:   ;  // unused opcode: no state change, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("%0t ns: %s: got %02h want %02h", $time, what, got, want);
    n_errors++;
  endtask

  // Values read here are the ones held before this edge, so the order of
  // processes within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (crypt_out_q.size() == 0) begin
        report_mismatch("result with no crypt request pending", out_tdata, 'x);
      end else begin
        want_byte = crypt_out_q.pop_front();
        if (out_tdata !== want_byte) report_mismatch("data_out", out_tdata, want_byte);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, switching between modes
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          rx_mode <= RX_OPEN;
          rx_left <= $urandom_range(5, 60);
        end
        1: begin
          rx_mode <= RX_RANDOM;
          rx_left <= $urandom_range(5, 40);
        end
        default: begin
          rx_mode <= RX_HOLD;
          rx_left <= $urandom_range(1, 25);
        end
      endcase
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= $urandom_range(0, 1);
      default:   out_tready <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drives one request and returns right after the edge that accepts it.
  // Requests go out in bursts; between bursts valid usually drops for a random gap.
  task automatic send_request(input logic [OPC_W-1:0]  opcode,
                              input logic [SLOT_W-1:0] slot,
                              input logic [BYTE_W-1:0] kbyte,
                              input logic [BYTE_W-1:0] din);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    predict_request(opcode, slot, kbyte, din);
    in_tvalid <= 1'b1;
    in_tuser  <= opcode;
    in_tdata  <= {2'b00, din, kbyte, slot};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic key_write(input logic [SLOT_W-1:0] slot, input logic [BYTE_W-1:0] kbyte);
    send_request(OP_KEY_WR, slot, kbyte, BYTE_W'($urandom));
  endtask

  task automatic key_schedule();
    send_request(OP_SCHED, SLOT_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic crypt(input logic [BYTE_W-1:0] din);
    send_request(OP_CRYPT, SLOT_W'($urandom), BYTE_W'($urandom), din);
  endtask

  // Hold off until every pending result has come out.
  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (crypt_out_q.size() != 0);
  endtask

  // Config writes must land only while the core is idle, which the core does not
  // enforce; a schedule may still be running with nothing pending, hence the extra wait.
  task automatic write_key_length(input logic [KEYLEN_W-1:0] len);
    wait_idle();
    repeat (SCHED_DRAIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    key_len_reg = len;
  endtask

  function automatic logic [KEYLEN_W-1:0] pick_key_length();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      default: return KEYLEN_W'($urandom_range(2, 126));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Crypt straight after reset runs on the identity permutation with zero
  // indices; opcode 3 in between must change nothing.
  task automatic test_reset_state();
    crypt(8'h00);
    send_request(OP_UNUSED, 6'h3f, 8'hff, 8'hff);
    crypt(8'hff);
    crypt(BYTE_W'($urandom));
  endtask

  // Key length zero behaves as one; only slot 0 feeds the schedule.
  // Slot 63 is written too but never read here.
  task automatic test_short_key();
    write_key_length(7'd0);
    key_write(6'd0, 8'hff);
    key_write(6'd63, 8'h00);
    key_schedule();
    crypt(8'h00);
    crypt(8'hff);
    crypt(8'h5a);
    write_key_length(7'd1);
    key_write(6'd0, 8'h00);
    key_schedule();
    crypt(8'h00);
    crypt(8'hff);
    crypt(8'ha5);
  endtask

  // Fill the whole key store, then schedule at the top length and above it
  // (above must saturate to the store size).
  task automatic test_full_key();
    for (int n = 0; n < DEF_MAX_KEY_BYTES; n++) key_write(SLOT_W'(n), BYTE_W'($urandom));
    write_key_length(7'd127);
    key_schedule();
    repeat (12) crypt(BYTE_W'($urandom));
    write_key_length(7'd64);
    key_schedule();
    repeat (12) crypt(BYTE_W'($urandom));
  endtask

  // Mostly well-formed sessions (key bytes, schedule, a run of crypts) with
  // random content, plus bare crypt runs, noise and full drains.
  // Every key slot has been written by now, so any schedule is legal.
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned next_cfg;
    next_cfg = n_sent + 120;
    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= next_cfg) begin
        write_key_length(pick_key_length());
        next_cfg = n_sent + $urandom_range(80, 160);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        repeat ($urandom_range(0, 6))
          key_write(SLOT_W'($urandom_range(0, eff_key_len() - 1)), BYTE_W'($urandom));
        key_schedule();
        repeat ($urandom_range(4, 40)) crypt(BYTE_W'($urandom));
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 20)) crypt(BYTE_W'($urandom));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 10))
          send_request(OPC_W'($urandom), SLOT_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom));
      end else begin
        wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_cipher_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_short_key();
    test_full_key();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/rc4_pkg.sv
src/rc4_ctrl.sv
src/rc4_dp.sv
src/rc4_stream_cipher_core.sv
test/tb_rc4_stream_cipher_core.sv
